[rtl/alac_pkg.sv]
// Shared widths, operation codes and walker interface types of the alpha line accumulator.
`default_nettype none

package alac_pkg;

  localparam int DEF_MAX_SIZE      = 512;
  localparam int DEF_MAX_PEGS      = 512;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int OP_W        = 2;
  localparam int IDX_W       = 9;
  localparam int COORD_W     = 9;
  localparam int BRIGHT_W    = 8;
  localparam int CFG_SIZE_W  = 10;
  localparam int CFG_ALPHA_W = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_AW      = 3;

  localparam logic [CFG_SIZE_W-1:0]  SIZE_RESET  = 10'd360;
  localparam logic [CFG_ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // Register index, taken from paddr[2].
  localparam logic REG_IMAGE_SIZE  = 1'b0;
  localparam logic REG_BLEND_ALPHA = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   start;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } walk_req_t;

  typedef struct packed {
    logic   valid;
    logic   last;
    coord_t x;
    coord_t y;
  } walk_pix_t;

endpackage

`default_nettype wire

[rtl/alpha_line_accumulator_unit.sv]
// Top level of the alpha line accumulator: peg table, intensity store and control.
//
//   Port group   Direction  Handshake                Carries
//   in_*         request    in_valid / in_ready      operation, peg and pixel fields
//   out_*        result     out_valid / out_ready    brightness, index_error
//   APB          config     psel, penable, pready    image_size (0x0), blend_alpha (0x4)
//
// Load, bad-index and unknown requests go from the idle to the done state; a read passes
// through the pixel-read state first. A draw fetches both pegs, walks its max(dx, dy) + 1
// pixels, one read-modify-write per cycle through the store's single read and write port,
// and drains the blend pipeline. After reset the intensity store is zeroed one entry per cycle,
// MAX_SIZE * MAX_SIZE entries (262144 by default); in_ready stays low until that pass ends.
// One request is worked at a time; a finished result waits in a holding register while the
// output register is still full, and the next request is taken once that result has moved on.
`default_nettype none

module alpha_line_accumulator_unit #(
  parameter int MAX_SIZE      = alac_pkg::DEF_MAX_SIZE,
  parameter int MAX_PEGS      = alac_pkg::DEF_MAX_PEGS,
  parameter int FRACTION_BITS = alac_pkg::DEF_FRACTION_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [alac_pkg::OP_W-1:0]        in_operation,
  input  logic [alac_pkg::IDX_W-1:0]       in_peg_index,
  input  logic [alac_pkg::COORD_W-1:0]     in_peg_x,
  input  logic [alac_pkg::COORD_W-1:0]     in_peg_y,
  input  logic [alac_pkg::IDX_W-1:0]       in_from_peg,
  input  logic [alac_pkg::IDX_W-1:0]       in_to_peg,
  input  logic [alac_pkg::COORD_W-1:0]     in_read_x,
  input  logic [alac_pkg::COORD_W-1:0]     in_read_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [alac_pkg::BRIGHT_W-1:0]    out_brightness,
  output logic                             out_index_error,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [alac_pkg::CFG_AW-1:0]      paddr,
  input  logic [alac_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [alac_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import alac_pkg::*;

  localparam int DEPTH   = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PEG_AW  = $clog2(MAX_PEGS);
  localparam int FW      = FRACTION_BITS;
  localparam int SIZE_W  = ($clog2(MAX_SIZE + 1) > CFG_SIZE_W) ? $clog2(MAX_SIZE + 1)
                                                               : CFG_SIZE_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PEG1  = 3'd2;
  localparam logic [2:0] ST_PEG2  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_RDPX  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // Configuration registers
  logic [CFG_SIZE_W-1:0]  image_size_r;
  logic [CFG_ALPHA_W-1:0] blend_alpha_r;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r  <= SIZE_RESET;
      blend_alpha_r <= ALPHA_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMAGE_SIZE:  image_size_r  <= pwdata[CFG_SIZE_W-1:0];
        REG_BLEND_ALPHA: blend_alpha_r <= pwdata[CFG_ALPHA_W-1:0];
        default:         image_size_r  <= image_size_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_SIZE:  prdata = CFG_DATA_W'(image_size_r);
      REG_BLEND_ALPHA: prdata = CFG_DATA_W'(blend_alpha_r);
      default:         prdata = '0;
    endcase
  end

  // Effective size and alpha scaled to the fraction width
  logic [SIZE_W-1:0]         eff_size;
  logic [FW+CFG_ALPHA_W-1:0] alpha_wide;
  logic [FW-1:0]             alpha_eff;

  always_comb begin
    if (image_size_r == '0) begin
      eff_size = SIZE_W'(1);
    end else if (SIZE_W'(image_size_r) > SIZE_W'(MAX_SIZE)) begin
      eff_size = SIZE_W'(MAX_SIZE);
    end else begin
      eff_size = SIZE_W'(image_size_r);
    end
    alpha_wide = {blend_alpha_r, {FW{1'b0}}} >> CFG_ALPHA_W;
    alpha_eff  = alpha_wide[FW-1:0];
  end

  // Control state
  logic [2:0]            state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_addr_r;
  logic [PEG_AW-1:0]     to_idx_r;
  coord_t                x0_r, y0_r;
  logic [BRIGHT_W-1:0]   res_bright_r, res_bright_nxt;
  logic                  res_err_r, res_err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BRIGHT_W-1:0]   out_bright_r;
  logic                  out_err_r;

  logic                  in_acc;
  logic                  load_ok, draw_ok, read_ok;
  logic                  peg_we;
  logic [PEG_AW-1:0]     peg_ra;
  logic [2*COORD_W-1:0]  peg_rdata_r;
  logic                  out_load;

  walk_req_t             walk_req;
  walk_pix_t             pix;

  // Intensity pipeline
  coord_t                rd_x, rd_y;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  pix_in;
  logic                  p1_valid_r;
  logic [ADDR_W-1:0]     p1_addr_r;
  logic                  p2_valid_r;
  logic [ADDR_W-1:0]     p2_addr_r;
  logic [FW-1:0]         p2_i_r;
  logic [FW-1:0]         p2_add_r;
  logic [FW-1:0]         int_rdata_r;
  logic [FW:0]           inv_i;
  logic [2*FW:0]         prod;
  logic [FW:0]           blend_sum;
  logic [FW-1:0]         blend_val;
  logic [FW+BRIGHT_W-1:0] bright_full;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_ok  = 32'(in_peg_index) < 32'(MAX_PEGS);
  assign draw_ok  = (32'(in_from_peg) < 32'(MAX_PEGS)) && (32'(in_to_peg) < 32'(MAX_PEGS));
  assign read_ok  = (SIZE_W'(in_read_x) < eff_size) && (SIZE_W'(in_read_y) < eff_size);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    res_bright_nxt = res_bright_r;
    res_err_nxt    = res_err_r;
    peg_we         = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_bright_nxt = '0;
          res_err_nxt    = 1'b0;
          state_nxt      = ST_DONE;
          case (in_operation)
            OP_LOAD: begin
              peg_we      = load_ok;
              res_err_nxt = !load_ok;
            end
            OP_DRAW: begin
              res_err_nxt = !draw_ok;
              if (draw_ok) begin
                state_nxt = ST_PEG1;
              end
            end
            OP_READ: begin
              res_err_nxt = !read_ok;
              if (read_ok) begin
                state_nxt = ST_RDPX;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PEG1: state_nxt = ST_PEG2;
      ST_PEG2: state_nxt = ST_WALK;
      ST_WALK: begin
        if (pix.valid && pix.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_valid_r && !p2_valid_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RDPX: begin
        res_bright_nxt = bright_full[FW+BRIGHT_W-1:FW];
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      p1_valid_r  <= pix_in;
      p2_valid_r  <= p1_valid_r;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    res_bright_r <= res_bright_nxt;
    res_err_r    <= res_err_nxt;
    if (in_acc) begin
      to_idx_r <= PEG_AW'(in_to_peg);
    end
    if (state_r == ST_PEG1) begin
      x0_r <= peg_rdata_r[2*COORD_W-1:COORD_W];
      y0_r <= peg_rdata_r[COORD_W-1:0];
    end
    if (out_load) begin
      out_bright_r <= res_bright_r;
      out_err_r    <= res_err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_brightness  = out_bright_r;
  assign out_index_error = out_err_r;

  // Peg table: x in the upper half of each entry, y in the lower half
  logic [2*COORD_W-1:0] peg_mem [MAX_PEGS];

  assign peg_ra = (state_r == ST_PEG1) ? to_idx_r : PEG_AW'(in_from_peg);

  always_ff @(posedge clk) begin
    if (peg_we) begin
      peg_mem[PEG_AW'(in_peg_index)] <= {in_peg_x, in_peg_y};
    end
    peg_rdata_r <= peg_mem[peg_ra];
  end

  assign walk_req = '{start: (state_r == ST_PEG2),
                      x0: x0_r, y0: y0_r,
                      x1: peg_rdata_r[2*COORD_W-1:COORD_W],
                      y1: peg_rdata_r[COORD_W-1:0]};

  alac_line_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (walk_req),
    .pix   (pix)
  );

  // Read-modify-write: read in the walk cycle, multiply next cycle, write back the one after.
  // A Bresenham line never visits a pixel twice, so entries in flight never collide.
  always_comb begin
    rd_x    = (state_r == ST_IDLE) ? in_read_x : pix.x;
    rd_y    = (state_r == ST_IDLE) ? in_read_y : pix.y;
    rd_addr = ADDR_W'(32'(rd_y) * 32'(MAX_SIZE) + 32'(rd_x));
    pix_in  = (state_r == ST_WALK) && pix.valid &&
              (SIZE_W'(pix.x) < eff_size) && (SIZE_W'(pix.y) < eff_size);

    inv_i   = {1'b1, {FW{1'b0}}} - {1'b0, int_rdata_r};
    prod    = (2*FW+1)'(alpha_eff) * (2*FW+1)'(inv_i);

    blend_sum = {1'b0, p2_i_r} + {1'b0, p2_add_r};
    blend_val = blend_sum[FW] ? {FW{1'b1}} : blend_sum[FW-1:0];

    bright_full = ({int_rdata_r, {BRIGHT_W{1'b0}}}) - (FW+BRIGHT_W)'(int_rdata_r);
  end

  always_ff @(posedge clk) begin
    p1_addr_r <= rd_addr;
    p2_addr_r <= p1_addr_r;
    p2_i_r    <= int_rdata_r;
    p2_add_r  <= prod[2*FW-1:FW];
  end

  logic [FW-1:0] int_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      int_mem[clr_addr_r] <= '0;
    end else if (p2_valid_r) begin
      int_mem[p2_addr_r] <= blend_val;
    end
    int_rdata_r <= int_mem[rd_addr];
  end

  // Checks
  a_no_blend_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !p2_valid_r)
    else $error("blend write-back during the clearing pass");

  a_rmw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_valid_r && p2_valid_r) |-> (p1_addr_r != p2_addr_r))
    else $error("pixel read while its own write-back is pending");

  a_walk_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    pix.valid |-> (state_r == ST_WALK))
    else $error("walker active outside the walk state");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (!p1_valid_r && !p2_valid_r))
    else $error("result issued before the blend pipeline drained");

endmodule

`default_nettype wire

[rtl/alac_line_walker.sv]
// Bresenham line stepper that presents one pixel of the line per cycle.
`default_nettype none

module alac_line_walker (
  input  logic                clk,
  input  logic                rst_n,
  input  alac_pkg::walk_req_t req,
  output alac_pkg::walk_pix_t pix
);
  import alac_pkg::*;

  localparam int ERR_W = COORD_W + 2;

  logic                    active_r, active_nxt;
  coord_t                  x_r, y_r, x1_r, y1_r;
  coord_t                  dx_r, dy_r;
  logic                    sx_neg_r, sy_neg_r;
  logic signed [ERR_W-1:0] err_r;

  logic signed [ERR_W:0]   e2, dx_s, dy_s, err_sum;
  logic                    step_x, step_y, at_end;
  coord_t                  dx_start, dy_start;

  always_comb begin
    e2      = {err_r, 1'b0};
    dx_s    = $signed({3'b000, dx_r});
    dy_s    = $signed({3'b000, dy_r});
    step_x  = e2 > -dy_s;
    step_y  = e2 < dx_s;
    err_sum = {err_r[ERR_W-1], err_r};
    if (step_x) begin
      err_sum = err_sum - dy_s;
    end
    if (step_y) begin
      err_sum = err_sum + dx_s;
    end
    at_end     = (x_r == x1_r) && (y_r == y1_r);
    dx_start   = (req.x1 >= req.x0) ? req.x1 - req.x0 : req.x0 - req.x1;
    dy_start   = (req.y1 >= req.y0) ? req.y1 - req.y0 : req.y0 - req.y1;
    active_nxt = req.start || (active_r && !at_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r      <= req.x0;
      y_r      <= req.y0;
      x1_r     <= req.x1;
      y1_r     <= req.y1;
      dx_r     <= dx_start;
      dy_r     <= dy_start;
      sx_neg_r <= !(req.x0 < req.x1);
      sy_neg_r <= !(req.y0 < req.y1);
      err_r    <= $signed({2'b00, dx_start}) - $signed({2'b00, dy_start});
    end else if (active_r && !at_end) begin
      err_r <= err_sum[ERR_W-1:0];
      if (step_x) begin
        x_r <= sx_neg_r ? x_r - coord_t'(1) : x_r + coord_t'(1);
      end
      if (step_y) begin
        y_r <= sy_neg_r ? y_r - coord_t'(1) : y_r + coord_t'(1);
      end
    end
  end

  assign pix = '{valid: active_r, last: at_end, x: x_r, y: y_r};

endmodule

`default_nettype wire

[test/tb_alpha_line_accumulator_unit.sv]
// Testbench for the alpha line accumulator: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb_alpha_line_accumulator_unit;
  import alac_pkg::*;

  localparam int MAX_SIZE        = DEF_MAX_SIZE;
  localparam int FRAC_BITS       = DEF_FRACTION_BITS;
  localparam longint unsigned ONE_FRAC = 64'd1 << FRAC_BITS;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_COUNT     = 8;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int DRAIN_CYCLES    = 16;
  // Clearing pass plus every request at the longest line, gap and stall, several times over.
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [IDX_W-1:0]   peg_index;
    logic [COORD_W-1:0] peg_x;
    logic [COORD_W-1:0] peg_y;
    logic [IDX_W-1:0]   from_peg;
    logic [IDX_W-1:0]   to_peg;
    logic [COORD_W-1:0] read_x;
    logic [COORD_W-1:0] read_y;
  } request_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0] brightness;
    logic                index_error;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_operation = '0;
  logic [IDX_W-1:0]      in_peg_index = '0;
  logic [COORD_W-1:0]    in_peg_x = '0;
  logic [COORD_W-1:0]    in_peg_y = '0;
  logic [IDX_W-1:0]      in_from_peg = '0;
  logic [IDX_W-1:0]      in_to_peg = '0;
  logic [COORD_W-1:0]    in_read_x = '0;
  logic [COORD_W-1:0]    in_read_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BRIGHT_W-1:0]   out_brightness;
  logic                  out_index_error;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_AW-1:0]     paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state: a shadow of the peg table, the intensity store and both registers.
  bit [FRAC_BITS-1:0]     shadow_intensity [MAX_SIZE*MAX_SIZE];
  logic [COORD_W-1:0]     shadow_peg_x [MAX_SIZE];
  logic [COORD_W-1:0]     shadow_peg_y [MAX_SIZE];
  bit                     peg_loaded [MAX_SIZE];
  logic [CFG_SIZE_W-1:0]  shadow_size  = SIZE_RESET;
  logic [CFG_ALPHA_W-1:0] shadow_alpha = ALPHA_RESET;

  result_t expected_results[$];
  int      loaded_pegs[$];
  int      phase_pegs[$];
  bit      steady_flow = 1'b0;

  int     mismatch_count = 0;
  int     results_checked = 0;
  int     load_count = 0;
  int     draw_count = 0;
  int     pixels_blended = 0;
  int     read_count = 0;
  int     lit_reads = 0;
  int     refused_reads = 0;
  int     unused_count = 0;
  int     setting_count = 0;
  int     stall_left = 0;
  longint cycle_count = 0;

  alpha_line_accumulator_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_peg_index    (in_peg_index),
    .in_peg_x        (in_peg_x),
    .in_peg_y        (in_peg_y),
    .in_from_peg     (in_from_peg),
    .in_to_peg       (in_to_peg),
    .in_read_x       (in_read_x),
    .in_read_y       (in_read_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_brightness  (out_brightness),
    .out_index_error (out_index_error),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: compare each accepted result, then draw the next stall.
  always @(posedge clk) begin : result_checker
    result_t want;
    int      stall;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, brightness %0d index_error %0d", $time,
                 out_brightness, out_index_error);
      end else begin
        want = expected_results.pop_front();
        if (out_brightness !== want.brightness) begin
          mismatch_count++;
          $display("%0t: brightness mismatch, expected %0d, got %0d", $time,
                   want.brightness, out_brightness);
        end
        if (out_index_error !== want.index_error) begin
          mismatch_count++;
          $display("%0t: index_error mismatch, expected %0d, got %0d", $time,
                   want.index_error, out_index_error);
        end
      end
      stall = steady_flow ? 0 : int'($urandom_range(0, 3));
      out_ready <= (stall == 0);
      stall_left <= stall;
    end else if (!out_ready) begin
      if (stall_left <= 1) out_ready <= 1'b1;
      stall_left <= stall_left - 1;
    end
  end

  function automatic int effective_size();
    if (shadow_size == 0) return 1;
    if (shadow_size > MAX_SIZE) return MAX_SIZE;
    return int'(shadow_size);
  endfunction

  // Walks the Bresenham line and blends every pixel that falls inside the image.
  task automatic blend_line(input int x0, input int y0, input int x1, input int y1);
    int dx, dy, sx, sy, err, e2, x, y, sz, addr;
    longint unsigned level, alpha_q;
    bit done;
    sz = effective_size();
    alpha_q = 64'(shadow_alpha);
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    x = x0;
    y = y0;
    done = 1'b0;
    while (!done) begin
      if (x >= 0 && y >= 0 && x < sz && y < sz) begin
        addr = y * MAX_SIZE + x;
        level = 64'(shadow_intensity[addr]);
        level = level + ((alpha_q * (ONE_FRAC - level)) >> FRAC_BITS);
        if (level >= ONE_FRAC) level = ONE_FRAC - 1;
        shadow_intensity[addr] = level[FRAC_BITS-1:0];
        pixels_blended++;
      end
      if (x == x1 && y == y1) begin
        done = 1'b1;
      end else begin
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          x += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y += sy;
        end
      end
    end
  endtask

  // Applies one accepted request to the shadow state and queues the result it must produce.
  // Peg indexes are 9 bits against a 512-entry table, so a bad peg index cannot occur.
  task automatic predict_result(input request_t r);
    result_t         res;
    longint unsigned level;
    int              sz;
    res.brightness = '0;
    res.index_error = 1'b0;
    sz = effective_size();
    case (r.operation)
      OP_LOAD: begin
        shadow_peg_x[r.peg_index] = r.peg_x;
        shadow_peg_y[r.peg_index] = r.peg_y;
        if (!peg_loaded[r.peg_index]) loaded_pegs.insert(loaded_pegs.size(), int'(r.peg_index));
        peg_loaded[r.peg_index] = 1'b1;
        phase_pegs.insert(phase_pegs.size(), int'(r.peg_index));
        load_count++;
      end
      OP_DRAW: begin
        blend_line(int'(shadow_peg_x[r.from_peg]), int'(shadow_peg_y[r.from_peg]),
                   int'(shadow_peg_x[r.to_peg]), int'(shadow_peg_y[r.to_peg]));
        draw_count++;
      end
      OP_READ: begin
        read_count++;
        if (int'(r.read_x) >= sz || int'(r.read_y) >= sz) begin
          res.index_error = 1'b1;
          refused_reads++;
        end else begin
          level = 64'(shadow_intensity[int'(r.read_y) * MAX_SIZE + int'(r.read_x)]);
          res.brightness = BRIGHT_W'((level * 255) >> FRAC_BITS);
          if (res.brightness != 0) lit_reads++;
        end
      end
      default: unused_count++;
    endcase
    expected_results.insert(expected_results.size(), res);
  endtask

  task automatic send_request(input request_t r);
    int gap;
    gap = steady_flow ? 0 : int'($urandom_range(0, 3));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_operation <= r.operation;
    in_peg_index <= r.peg_index;
    in_peg_x     <= r.peg_x;
    in_peg_y     <= r.peg_y;
    in_from_peg  <= r.from_peg;
    in_to_peg    <= r.to_peg;
    in_read_x    <= r.read_x;
    in_read_y    <= r.read_y;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_result(r);
  endtask

  // Holds the sender off until every queued result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Writes one register, reads it back, and mirrors it in the predictor.
  task automatic set_register(input logic idx, input int value);
    logic [CFG_AW-1:0]     reg_addr;
    logic [CFG_DATA_W-1:0] readback;
    int                    field_w;
    reg_addr = CFG_AW'({idx, 2'b00});
    field_w = (idx == REG_IMAGE_SIZE) ? CFG_SIZE_W : CFG_ALPHA_W;
    paddr   <= reg_addr;
    pwdata  <= CFG_DATA_W'(value);
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_IMAGE_SIZE) shadow_size = CFG_SIZE_W'(value);
    else shadow_alpha = CFG_ALPHA_W'(value);
    setting_count++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    if ((readback & ((32'd1 << field_w) - 1)) !== (value & ((32'd1 << field_w) - 1))) begin
      mismatch_count++;
      $display("%0t: register %0d readback mismatch, expected %0d, got %0d", $time, idx,
               value, readback);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // A loaded peg for the line ends: mostly from the current cluster, now and then any.
  function automatic int random_peg();
    if (phase_pegs.size() != 0 && $urandom_range(0, 99) < 85)
      return phase_pegs[$urandom_range(0, phase_pegs.size() - 1)];
    if (loaded_pegs.size() != 0)
      return loaded_pegs[$urandom_range(0, loaded_pegs.size() - 1)];
    return 0;
  endfunction

  function automatic int near_coord(input int c);
    int v;
    v = c + int'($urandom_range(0, 48)) - 24;
    if (v < 0) v = 0;
    if (v > MAX_SIZE - 1) v = MAX_SIZE - 1;
    return v;
  endfunction

  // Fields that the operation ignores carry random values; line ends stay on loaded pegs.
  function automatic request_t scrambled_request(input logic [OP_W-1:0] op);
    request_t r;
    r.operation = op;
    r.peg_index = IDX_W'($urandom_range(0, MAX_SIZE - 1));
    r.peg_x     = COORD_W'($urandom_range(0, MAX_SIZE - 1));
    r.peg_y     = COORD_W'($urandom_range(0, MAX_SIZE - 1));
    r.from_peg  = IDX_W'(random_peg());
    r.to_peg    = IDX_W'(random_peg());
    r.read_x    = COORD_W'($urandom_range(0, MAX_SIZE - 1));
    r.read_y    = COORD_W'($urandom_range(0, MAX_SIZE - 1));
    return r;
  endfunction

  function automatic request_t make_load(input int idx, input int x, input int y);
    request_t r;
    r = scrambled_request(OP_LOAD);
    r.peg_index = IDX_W'(idx);
    r.peg_x = COORD_W'(x);
    r.peg_y = COORD_W'(y);
    return r;
  endfunction

  function automatic request_t make_draw(input int from_idx, input int to_idx);
    request_t r;
    r = scrambled_request(OP_DRAW);
    r.from_peg = IDX_W'(from_idx);
    r.to_peg = IDX_W'(to_idx);
    return r;
  endfunction

  function automatic request_t make_read(input int x, input int y);
    request_t r;
    r = scrambled_request(OP_READ);
    r.read_x = COORD_W'(x);
    r.read_y = COORD_W'(y);
    return r;
  endfunction

  // Reads on the freshly cleared store, at the image edge and just past it, then an unused code.
  task automatic test_cleared_store();
    send_request(make_read(0, 0));
    send_request(make_read(359, 359));
    send_request(make_read(360, 0));
    send_request(make_read(0, 511));
    send_request(scrambled_request(OP_UNUSED));
  endtask

  // Horizontal, anti-diagonal, clipped diagonal and single-point lines at the reset settings.
  task automatic test_line_shapes();
    send_request(make_load(0, 0, 0));
    send_request(make_load(511, 511, 511));
    send_request(make_load(1, 359, 0));
    send_request(make_load(2, 0, 359));
    send_request(make_draw(0, 1));
    send_request(make_draw(1, 2));
    send_request(make_draw(0, 511));
    send_request(make_draw(2, 2));
    send_request(make_read(0, 0));
    send_request(make_read(180, 0));
    send_request(make_read(100, 259));
    send_request(make_read(359, 359));
  endtask

  // Full alpha on the largest image, zero alpha at a one-pixel size, then a clamped size.
  task automatic test_register_extremes();
    wait_drained();
    set_register(REG_IMAGE_SIZE, MAX_SIZE);
    set_register(REG_BLEND_ALPHA, 65535);
    send_request(make_draw(511, 0));
    send_request(make_read(511, 511));
    send_request(make_read(0, 0));
    wait_drained();
    set_register(REG_IMAGE_SIZE, 0);
    set_register(REG_BLEND_ALPHA, 0);
    send_request(make_draw(0, 1));
    send_request(make_read(0, 0));
    send_request(make_read(1, 0));
    wait_drained();
    set_register(REG_IMAGE_SIZE, 1023);
    set_register(REG_BLEND_ALPHA, 1);
    send_request(make_read(511, 0));
  endtask

  // Each phase picks a setting and a cluster center, loads a few pegs there, then mixes
  // loads, draws, reads and unused codes around it.
  task automatic test_random_phases();
    int size_set, alpha_set, sz, cx, cy, pick, ref_peg, x, y;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin size_set = 360;  alpha_set = 6554;  end
        1: begin size_set = 512;  alpha_set = 65535; end
        2: begin size_set = 1;    alpha_set = 1;     end
        3: begin size_set = 200;  alpha_set = int'($urandom_range(0, 65535)); end
        4: begin size_set = 0;    alpha_set = 32768; end
        5: begin size_set = 1023; alpha_set = 0;     end
        6: begin size_set = 37;   alpha_set = int'($urandom_range(0, 65535)); end
        default: begin size_set = 512; alpha_set = int'($urandom_range(0, 65535)); end
      endcase
      wait_drained();
      set_register(REG_IMAGE_SIZE, size_set);
      set_register(REG_BLEND_ALPHA, alpha_set);
      steady_flow = (p % 3 == 2);
      sz = effective_size();
      cx = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, MAX_SIZE - 1))
                                       : int'($urandom_range(0, sz - 1));
      cy = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, MAX_SIZE - 1))
                                       : int'($urandom_range(0, sz - 1));
      phase_pegs.delete();
      repeat (8)
        send_request(make_load(int'($urandom_range(0, MAX_SIZE - 1)), near_coord(cx),
                               near_coord(cy)));
      repeat (ITEMS_PER_PHASE - 8) begin
        pick = int'($urandom_range(0, 99));
        if (pick < 20) begin
          if ($urandom_range(0, 99) < 15)
            send_request(make_load(int'($urandom_range(0, MAX_SIZE - 1)),
                                   int'($urandom_range(0, MAX_SIZE - 1)),
                                   int'($urandom_range(0, MAX_SIZE - 1))));
          else
            send_request(make_load(int'($urandom_range(0, MAX_SIZE - 1)), near_coord(cx),
                                   near_coord(cy)));
        end else if (pick < 65) begin
          send_request(make_draw(random_peg(), random_peg()));
        end else if (pick < 95) begin
          pick = int'($urandom_range(0, 99));
          if (pick < 35) begin
            // Reads at loaded peg positions, where the ends of lines drawn from or to those pegs lie.
            ref_peg = random_peg();
            x = int'(shadow_peg_x[ref_peg]);
            y = int'(shadow_peg_y[ref_peg]);
          end else if (pick < 70) begin
            x = near_coord(cx);
            y = near_coord(cy);
          end else if (pick < 85 || sz >= MAX_SIZE) begin
            x = int'($urandom_range(0, MAX_SIZE - 1));
            y = int'($urandom_range(0, MAX_SIZE - 1));
          end else if ($urandom_range(0, 1) == 0) begin
            x = int'($urandom_range(sz, MAX_SIZE - 1));
            y = int'($urandom_range(0, MAX_SIZE - 1));
          end else begin
            x = int'($urandom_range(0, MAX_SIZE - 1));
            y = int'($urandom_range(sz, MAX_SIZE - 1));
          end
          send_request(make_read(x, y));
        end else begin
          send_request(scrambled_request(OP_UNUSED));
        end
        if ($urandom_range(0, 79) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_cleared_store();
    test_line_shapes();
    test_register_extremes();
    test_random_phases();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d loads, %0d draws over %0d in-image pixels, %0d reads",
             load_count, draw_count, pixels_blended, read_count);
    $display("(%0d lit, %0d refused), %0d unused codes; %0d results, %0d register writes.",
             lit_reads, refused_reads, unused_count, results_checked, setting_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/alac_pkg.sv
rtl/alac_line_walker.sv
rtl/alpha_line_accumulator_unit.sv
test/tb_alpha_line_accumulator_unit.sv
